// ===== hw/rtl/dce_pkg.sv =====
package dce_pkg;

    localparam int DEF_MAX_FIELDS = 6;
    localparam int DEF_FIELD_BITS = 31;

    localparam int NUM_FIELDS = 6;
    localparam int CNT_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int EPOCH_W    = 49;
    localparam int YEAR_W     = 8;
    localparam int MONTH_W    = 4;
    localparam int DAYS_W     = 16;
    localparam int DBM_W      = 9;

    localparam int IDX_DAY    = 0;
    localparam int IDX_MONTH  = 1;
    localparam int IDX_YEAR   = 2;
    localparam int IDX_HOUR   = 3;
    localparam int IDX_MINUTE = 4;
    localparam int IDX_SECOND = 5;

    localparam int YEAR_BASE     = 1970;
    localparam int YEAR_SPAN     = 129;
    localparam int MONTH_COUNT   = 12;
    localparam int DAYS_PER_YEAR = 365;

    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_DATE   = 3'd1,
        ST_FEW_FIELDS = 3'd2,
        ST_YEAR       = 3'd3,
        ST_MONTH      = 3'd4,
        ST_NEG_TIME   = 3'd5,
        ST_END_COMMA  = 3'd6,
        ST_OVERFLOW   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_LETTER,
        PH_AFTER,
        PH_LEAD,
        PH_DIGITS,
        PH_IGNORE
    } phase_t;

    typedef enum logic [2:0] {
        CTL_PARSE,
        CTL_END,
        CTL_CHECK,
        CTL_HOUR,
        CTL_MINUTE,
        CTL_SECOND,
        CTL_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        MAC_HOUR,
        MAC_MINUTE,
        MAC_SECOND
    } mac_sel_t;

    typedef struct packed {
        logic     take;
        logic     finish;
        logic     check;
        logic     mac_en;
        mac_sel_t mac_sel;
        logic     load;
    } dp_cmd_t;

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] mm);
        logic [DBM_W-1:0] d;
        unique case (mm)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/dce_ctrl.sv =====
module dce_ctrl
    import dce_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last_byte,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_PARSE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_PARSE: begin
                if (s_valid && s_last_byte) begin
                    state_next = CTL_END;
                end
            end
            CTL_END:    state_next = CTL_CHECK;
            CTL_CHECK:  state_next = CTL_HOUR;
            CTL_HOUR:   state_next = CTL_MINUTE;
            CTL_MINUTE: state_next = CTL_SECOND;
            CTL_SECOND: state_next = CTL_DONE;
            CTL_DONE: begin
                if (out_free) begin
                    state_next = CTL_PARSE;
                end
            end
            default:    state_next = CTL_PARSE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == CTL_PARSE);
        cmd.take     = (state_reg == CTL_PARSE) && s_valid;
        cmd.finish   = (state_reg == CTL_END);
        cmd.check    = (state_reg == CTL_CHECK);
        cmd.mac_en   = (state_reg == CTL_HOUR) || (state_reg == CTL_MINUTE)
                       || (state_reg == CTL_SECOND);
        cmd.load     = (state_reg == CTL_DONE) && out_free;
        unique case (state_reg)
            CTL_HOUR:   cmd.mac_sel = MAC_HOUR;
            CTL_MINUTE: cmd.mac_sel = MAC_MINUTE;
            default:    cmd.mac_sel = MAC_SECOND;
        endcase
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/dce_datapath.sv =====
module dce_datapath
    import dce_pkg::*;
#(
    parameter int MAX_FIELDS = DEF_MAX_FIELDS,
    parameter int FIELD_BITS = DEF_FIELD_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    input  logic [7:0]                text_byte,
    output logic [STATUS_W-1:0]       status,
    output logic signed [EPOCH_W-1:0] epoch_seconds
);

    localparam int FW    = FIELD_BITS + 1;
    localparam int DIG_W = FIELD_BITS + 4;
    localparam int ACC_W = (FIELD_BITS + 19 > EPOCH_W + 1) ? FIELD_BITS + 19 : EPOCH_W + 1;

    localparam logic signed [FW-1:0] YEAR_LO  = FW'(YEAR_BASE);
    localparam logic signed [FW-1:0] YEAR_HI  = FW'(YEAR_BASE + YEAR_SPAN);
    localparam logic signed [FW-1:0] MONTH_LO = FW'(1);
    localparam logic signed [FW-1:0] MONTH_HI = FW'(MONTH_COUNT);

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [FIELD_BITS-1:0]  digits_reg, digits_next;
    logic                   neg_reg, neg_next;
    status_t                err_reg, err_next;
    logic                   store_en;
    logic signed [FW-1:0]   field_reg [MAX_FIELDS];
    logic signed [FW-1:0]   field_val [NUM_FIELDS];

    // byte decode
    logic                   is_digit;
    logic                   is_comma;
    logic [3:0]             digit_val;
    logic [DIG_W-1:0]       digits_ext;
    logic [DIG_W-1:0]       dig_prod;
    logic                   dig_over;
    logic [FW-1:0]          field_mag;
    logic signed [FW-1:0]   field_new;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       max_cnt;

    // end of command arithmetic
    logic                   year_ok;
    logic                   month_ok;
    logic                   time_neg;
    logic [YEAR_W-1:0]      yy;
    logic [MONTH_W-1:0]     mm;
    logic                   day_dec;
    logic [DAYS_W-1:0]      base_days;
    logic signed [ACC_W-1:0] days;
    status_t                check_status;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_x24, acc_x60, mac_mul, mac_term, mac_out;
    status_t                status_reg;
    logic                   result_ovf;
    status_t                final_status;
    status_t                out_status_reg;
    logic signed [EPOCH_W-1:0] out_epoch_reg;

    assign is_digit   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign is_comma   = (text_byte == CH_COMMA);
    assign digit_val  = 4'(text_byte - CH_ZERO);
    assign digits_ext = DIG_W'(digits_reg);
    assign dig_prod   = (digits_ext << 3) + (digits_ext << 1) + DIG_W'(digit_val);
    assign dig_over   = |dig_prod[DIG_W-1:FIELD_BITS];
    assign field_mag  = FW'(digits_reg);
    assign field_new  = neg_reg ? $signed(-field_mag) : $signed(field_mag);
    assign count_inc  = count_reg + 1'b1;
    assign max_cnt    = CNT_W'(MAX_FIELDS);

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        neg_next    = neg_reg;
        err_next    = err_reg;
        store_en    = 1'b0;
        if (cmd.load) begin
            phase_next  = PH_LETTER;
            count_next  = '0;
            digits_next = '0;
            neg_next    = 1'b0;
            err_next    = ST_OK;
        end else if (cmd.finish) begin
            if (phase_reg == PH_LEAD) begin
                err_next   = ST_END_COMMA;
                phase_next = PH_IGNORE;
            end else if (phase_reg == PH_DIGITS) begin
                store_en   = 1'b1;
                count_next = count_inc;
                phase_next = PH_IGNORE;
            end
        end else if (cmd.take) begin
            unique case (phase_reg)
                PH_LETTER: begin
                    if (text_byte == CH_UPPER_H || text_byte == CH_LOWER_H) begin
                        phase_next = PH_AFTER;
                    end else begin
                        err_next   = ST_NOT_DATE;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_AFTER: begin
                    if (is_comma && count_reg < max_cnt) begin
                        digits_next = '0;
                        neg_next    = 1'b0;
                        phase_next  = PH_LEAD;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_LEAD, PH_DIGITS: begin
                    priority if (phase_reg == PH_LEAD && text_byte == CH_SPACE) begin
                        phase_next = PH_LEAD;
                    end else if (phase_reg == PH_LEAD && text_byte == CH_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_DIGITS;
                    end else if (phase_reg == PH_LEAD && text_byte == CH_PLUS) begin
                        phase_next = PH_DIGITS;
                    end else if (is_digit) begin
                        if (dig_over) begin
                            err_next   = ST_OVERFLOW;
                            phase_next = PH_IGNORE;
                        end else begin
                            digits_next = dig_prod[FIELD_BITS-1:0];
                            phase_next  = PH_DIGITS;
                        end
                    end else begin
                        store_en    = 1'b1;
                        count_next  = count_inc;
                        digits_next = '0;
                        neg_next    = 1'b0;
                        if (is_comma && count_inc < max_cnt) begin
                            phase_next = PH_LEAD;
                        end else begin
                            phase_next = PH_IGNORE;
                        end
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LETTER;
            count_reg  <= '0;
            digits_reg <= '0;
            neg_reg    <= 1'b0;
            err_reg    <= ST_OK;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            digits_reg <= digits_next;
            neg_reg    <= neg_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_FIELDS; i++) begin
            if (!aresetn || cmd.load) begin
                field_reg[i] <= '0;
            end else if (store_en && count_reg == CNT_W'(i)) begin
                field_reg[i] <= field_new;
            end
        end
    end

    // fields beyond the allowed count read as zero
    for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_field
        if (g < MAX_FIELDS) begin : g_used
            assign field_val[g] = field_reg[g];
        end else begin : g_absent
            assign field_val[g] = '0;
        end
    end

    assign year_ok   = (field_val[IDX_YEAR] >= YEAR_LO) && (field_val[IDX_YEAR] <= YEAR_HI);
    assign month_ok  = (field_val[IDX_MONTH] >= MONTH_LO) && (field_val[IDX_MONTH] <= MONTH_HI);
    assign time_neg  = field_val[IDX_HOUR][FW-1] || field_val[IDX_MINUTE][FW-1]
                       || field_val[IDX_SECOND][FW-1];
    assign yy        = YEAR_W'(field_val[IDX_YEAR][YEAR_W-1:0] - YEAR_W'(YEAR_BASE));
    assign mm        = MONTH_W'(field_val[IDX_MONTH][MONTH_W-1:0] - MONTH_W'(1));
    assign day_dec   = (mm < MONTH_W'(2)) || (2'(yy[1:0] + 2'd2) != 2'd0);
    assign base_days = DAYS_W'(yy) * DAYS_W'(DAYS_PER_YEAR)
                       + DAYS_W'((yy + YEAR_W'(1)) >> 2)
                       + DAYS_W'(days_before_month(mm));
    assign days      = ACC_W'(field_val[IDX_DAY]) + $signed(ACC_W'(base_days))
                       - $signed(ACC_W'(day_dec));

    always_comb begin
        priority if (err_reg != ST_OK) begin
            check_status = err_reg;
        end else if (count_reg < CNT_W'(3)) begin
            check_status = ST_FEW_FIELDS;
        end else if (!year_ok) begin
            check_status = ST_YEAR;
        end else if (!month_ok) begin
            check_status = ST_MONTH;
        end else if (time_neg) begin
            check_status = ST_NEG_TIME;
        end else begin
            check_status = ST_OK;
        end
    end

    // horner steps: days*24 + hour, *60 + minute, *60 + second
    assign acc_x24 = (acc_reg <<< 4) + (acc_reg <<< 3);
    assign acc_x60 = (acc_reg <<< 6) - (acc_reg <<< 2);

    always_comb begin
        unique case (cmd.mac_sel)
            MAC_HOUR: begin
                mac_mul  = acc_x24;
                mac_term = ACC_W'(field_val[IDX_HOUR]);
            end
            MAC_MINUTE: begin
                mac_mul  = acc_x60;
                mac_term = ACC_W'(field_val[IDX_MINUTE]);
            end
            MAC_SECOND: begin
                mac_mul  = acc_x60;
                mac_term = ACC_W'(field_val[IDX_SECOND]);
            end
            default: begin
                mac_mul  = acc_x60;
                mac_term = '0;
            end
        endcase
        mac_out = mac_mul + mac_term;
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            acc_reg    <= days;
            status_reg <= check_status;
        end else if (cmd.mac_en) begin
            acc_reg <= mac_out;
        end
    end

    assign result_ovf   = !(&acc_reg[ACC_W-1:EPOCH_W-1]) && (|acc_reg[ACC_W-1:EPOCH_W-1]);
    assign final_status = (status_reg == ST_OK && result_ovf) ? ST_OVERFLOW : status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= final_status;
            out_epoch_reg  <= (final_status == ST_OK) ? acc_reg[EPOCH_W-1:0] : '0;
        end
    end

    assign status        = out_status_reg;
    assign epoch_seconds = out_epoch_reg;

endmodule

// ===== hw/rtl/date_command_to_epoch_unit.sv =====
// the result item is registered in the done state, reached after the last byte is accepted
// throughput: one command byte per cycle while a command is parsed
// after the last byte s_ready stays low (longer while the prior result is unread) through the
// end-of-command states end, check, hour, minute, second (shared multiply-add step) and done
// reset: synchronous active-low aresetn clears the parser, fields and output valid
module date_command_to_epoch_unit
    import dce_pkg::*;
#(
    parameter int MAX_FIELDS = DEF_MAX_FIELDS,
    parameter int FIELD_BITS = DEF_FIELD_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_text_byte,
    input  logic                      s_last_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic signed [EPOCH_W-1:0] m_epoch_seconds
);

    dp_cmd_t cmd;

    dce_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    dce_datapath #(
        .MAX_FIELDS (MAX_FIELDS),
        .FIELD_BITS (FIELD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .text_byte     (s_text_byte),
        .status        (m_status),
        .epoch_seconds (m_epoch_seconds)
    );

endmodule

// ===== test/date_command_to_epoch_unit_test.sv =====
import dce_pkg::*;

typedef struct {
    status_t                    status;
    logic signed [EPOCH_W-1:0]  secs;
} epoch_result_t;

class epoch_scoreboard;
    localparam int     MAX_FIELDS  = DEF_MAX_FIELDS;
    localparam longint FIELD_MAX   = (longint'(1) <<< DEF_FIELD_BITS) - 1;
    localparam longint DAY_SECONDS = 24 * 60 * 60;
    localparam longint EPOCH_LIM   = longint'(1) <<< (EPOCH_W - 1);

    phase_t        phase;
    int            fields_seen;
    longint        magnitude;
    bit            negative;
    longint        field_val [NUM_FIELDS];
    status_t       first_error;
    epoch_result_t want_q [$];
    int            fail_count;

    function new();
        fail_count = 0;
        clear_command();
    endfunction

    function void clear_command();
        phase = PH_LETTER;
        fields_seen = 0;
        magnitude = 0;
        negative = 1'b0;
        foreach (field_val[i]) field_val[i] = 0;
        first_error = ST_OK;
    endfunction

    function void flag(status_t code);
        if (first_error == ST_OK) first_error = code;
        phase = PH_IGNORE;
    endfunction

    function void after_field(logic [7:0] b);
        if (fields_seen < MAX_FIELDS && fields_seen < NUM_FIELDS && b == CH_COMMA) begin
            magnitude = 0;
            negative = 1'b0;
            phase = PH_LEAD;
        end else begin
            phase = PH_IGNORE;
        end
    endfunction

    function void close_field();
        if (fields_seen < NUM_FIELDS) begin
            field_val[fields_seen] = negative ? -magnitude : magnitude;
            fields_seen++;
        end
        magnitude = 0;
        negative = 1'b0;
    endfunction

    function void push_digit(logic [7:0] b);
        longint grown;
        grown = magnitude * 10 + longint'(b - CH_ZERO);
        if (grown > FIELD_MAX) begin
            flag(ST_OVERFLOW);
        end else begin
            magnitude = grown;
            phase = PH_DIGITS;
        end
    endfunction

    function int pending();
        return want_q.size();
    endfunction

    // parse one accepted byte; the last byte of a command yields the expected result
    function void note_byte(logic [7:0] b, logic last);
        epoch_result_t want;
        longint        day, mon, yr, days, total;
        longint        month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        bit            is_digit;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        case (phase)
            PH_LETTER: begin
                if (b == CH_UPPER_H || b == CH_LOWER_H) phase = PH_AFTER;
                else flag(ST_NOT_DATE);
            end
            PH_AFTER: after_field(b);
            PH_LEAD: begin
                if (b == CH_MINUS) begin
                    negative = 1'b1;
                    phase = PH_DIGITS;
                end else if (b == CH_PLUS) begin
                    phase = PH_DIGITS;
                end else if (is_digit) begin
                    push_digit(b);
                end else if (b != CH_SPACE) begin
                    close_field();
                    after_field(b);
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    push_digit(b);
                end else begin
                    close_field();
                    after_field(b);
                end
            end
            default: ;
        endcase
        if (!last) return;

        want.status = ST_OK;
        want.secs = '0;
        if (first_error == ST_OK && phase == PH_LEAD) flag(ST_END_COMMA);
        if (first_error == ST_OK && phase == PH_DIGITS) close_field();
        if (first_error != ST_OK) begin
            want.status = first_error;
        end else if (fields_seen < 3) begin
            want.status = ST_FEW_FIELDS;
        end else begin
            day = field_val[IDX_DAY];
            mon = field_val[IDX_MONTH] - 1;
            yr = field_val[IDX_YEAR] - YEAR_BASE;
            if (yr < 0 || yr > YEAR_SPAN) begin
                want.status = ST_YEAR;
            end else if (mon < 0 || mon >= MONTH_COUNT) begin
                want.status = ST_MONTH;
            end else if (field_val[IDX_HOUR] < 0 || field_val[IDX_MINUTE] < 0
                         || field_val[IDX_SECOND] < 0) begin
                want.status = ST_NEG_TIME;
            end else begin
                // day of month counts from one, except in a leap year from march on
                if (mon < 2 || ((yr + 2) % 4) != 0) day--;
                days = yr * DAYS_PER_YEAR + (yr + 1) / 4 + month_start[mon] + day;
                total = days * DAY_SECONDS + field_val[IDX_HOUR] * 3600
                      + field_val[IDX_MINUTE] * 60 + field_val[IDX_SECOND];
                if (total < -EPOCH_LIM || total > EPOCH_LIM - 1) want.status = ST_OVERFLOW;
                else want.secs = total[EPOCH_W-1:0];
            end
        end
        want_q.push_back(want);
        clear_command();
    endfunction

    task report(string what);
        fail_count++;
        if (fail_count <= 50) $display("mismatch: %s", what);
    endtask

    task check_result(logic [STATUS_W-1:0] got_status, logic signed [EPOCH_W-1:0] got_secs);
        epoch_result_t want;
        if (want_q.size() == 0) begin
            report($sformatf("result with none expected, status %0d secs %0d",
                             got_status, got_secs));
            return;
        end
        want = want_q.pop_front();
        if (got_status !== want.status)
            report($sformatf("status got %0d want %0d", got_status, want.status));
        if (got_secs !== want.secs)
            report($sformatf("epoch_seconds got %0d want %0d", got_secs, want.secs));
    endtask
endclass

module date_command_to_epoch_unit_test;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [7:0] byte_q_t [$];

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [7:0]                s_text_byte;
    logic                      s_last_byte;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [STATUS_W-1:0]       m_status;
    logic signed [EPOCH_W-1:0] m_epoch_seconds;

    epoch_scoreboard board;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;

    date_command_to_epoch_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_epoch_seconds (m_epoch_seconds)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL date_command_to_epoch_unit");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready)
            board.check_result(m_status, m_epoch_seconds);
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(b, last);
    endtask

    task automatic send_command(input byte_q_t text);
        for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    endtask

    function automatic string field_text(int slot);
        longint v;
        string  sign;
        case ($urandom_range(24))
            0: return "";
            1: return ($urandom_range(1) != 0) ? "-" : "+";
            2: return $sformatf("%0d", longint'($urandom()) * 7);
            3: return $sformatf("%0d", $urandom() & 32'h7fff_ffff);
            default: ;
        endcase
        case (slot)
            IDX_DAY: begin
                if ($urandom_range(9) < 8) v = $urandom_range(31, 1);
                else v = longint'($urandom_range(600)) - 200;
            end
            IDX_MONTH: begin
                if ($urandom_range(9) < 8) v = $urandom_range(12, 1);
                else v = longint'($urandom_range(15)) - 1;
            end
            IDX_YEAR: begin
                if ($urandom_range(9) < 8) v = $urandom_range(2099, 1970);
                else v = $urandom_range(2120, 1950);
            end
            default: begin
                if ($urandom_range(9) < 8) v = $urandom_range(59);
                else v = longint'($urandom_range(200000)) - 1000;
            end
        endcase
        if (v < 0) return $sformatf("-%0d", -v);
        if ($urandom_range(9) == 0) sign = "+";
        return {sign, $sformatf("%0d", v)};
    endfunction

    // mostly well-formed date commands, the rest raw noise or a broken letter
    function automatic byte_q_t random_command();
        byte_q_t text;
        string   s;
        int      nfields;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
            return text;
        end
        s = ($urandom_range(1) != 0) ? "H" : "h";
        if ($urandom_range(9) < 8) nfields = $urandom_range(6, 3);
        else nfields = $urandom_range(8);
        for (int k = 0; k < nfields; k++) begin
            s = {s, ","};
            if ($urandom_range(4) == 0) s = {s, " "};
            if ($urandom_range(19) == 0) s = {s, "  "};
            s = {s, field_text(k)};
        end
        case ($urandom_range(15))
            0: s = {s, ","};
            1: s = {s, ", "};
            2: s = {s, " 12"};
            3: s = {s, "x,5"};
            default: ;
        endcase
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        if ($urandom_range(14) == 0) text[0] = 8'($urandom_range(255));
        return text;
    endfunction

    initial begin
        string   directed [] = '{
            "H,1,1,1970",
            "h,31,12,2099,23,59,59",
            "H,29,2,2000,12,0,1",
            "H,2147483647,12,2099,2147483647,2147483647,2147483647",
            "H,2147483648,1,2000",
            "H, -5,+3, 2004,1,,-",
            "H,,+,-",
            "H,1,1,2000,1,2,3,4,5",
            "H,1,1,2000 x",
            "H,1,1,1969,-1",
            "H,1,13,2000",
            "H,1,1,2000,0,-1",
            "H,1,1,2000,",
            "h,1,1,2000, ",
            "h,99999999999,",
            "H,1,1",
            "H",
            "Q,1,1,2000",
            "H1,1,2000"
        };
        int      src_idle [4] = '{0, 55, 0, 14};
        int      sink_stall [4] = '{0, 0, 55, 14};
        byte_q_t text;
        int      sent;

        board = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_text_byte <= '0;
        s_last_byte <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[d]) begin
            text.delete();
            for (int i = 0; i < directed[d].len(); i++) text.push_back(directed[d][i]);
            send_command(text);
        end

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_idle[p];
            sink_stall_pct = sink_stall[p];
            sent = 0;
            while (sent < 300) begin
                text = random_command();
                send_command(text);
                sent += text.size();
            end
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.fail_count == 0 && board.pending() == 0)
            $display("PASS date_command_to_epoch_unit");
        else
            $display("FAIL date_command_to_epoch_unit");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/dce_pkg.sv
hw/rtl/dce_ctrl.sv
hw/rtl/dce_datapath.sv
hw/rtl/date_command_to_epoch_unit.sv
test/date_command_to_epoch_unit_test.sv
